// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check, off while reset is held
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check, off while reset is held
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication check that also covers reset
`define ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tnpu_pkg.sv
package tnpu_pkg;

    localparam int CW       = 32;
    localparam int NVERT    = 9;
    localparam int EW       = CW + 1;
    localparam int PW       = 2 * EW;
    localparam int NW       = PW + 1;
    localparam int MW       = PW;
    localparam int KW       = 31;
    localparam int SQW      = 2 * KW;
    localparam int SW       = 64;
    localparam int LW       = SW / 2;
    localparam int RW       = LW + 2;
    localparam int NUMW     = LW + 1;
    localparam int FRAC     = 15;
    localparam int DW       = NUMW + FRAC + 1;
    localparam int QW       = 17;
    localparam int UVW      = 2 * CW;
    localparam int UV_SHIFT = 16;
    localparam int QUVW     = UVW - UV_SHIFT;
    localparam int SHW      = 8;
    localparam int BLW      = 7;
    localparam int CHUNK    = 8;
    localparam int CLW      = 4;
    localparam int NCHUNK   = (MW + CHUNK - 1) / CHUNK;
    localparam int CHW      = NCHUNK * CHUNK;
    localparam int CIW      = 4;
    localparam int SQRT_STEPS = LW;
    localparam int DIV_STEPS  = QW;
    localparam int QDEPTH   = 4;
    localparam int QAW      = 2;
    localparam int QCW      = 3;

    localparam logic [1:0] DROP_X = 2'd0;
    localparam logic [1:0] DROP_Y = 2'd1;
    localparam logic [1:0] DROP_Z = 2'd2;

    localparam logic [QW-1:0]         NORM_HALF   = 17'd32768;
    localparam logic [QW-1:0]         NORM_ONE    = 17'd65536;
    localparam logic [CW-1:0]         SCALE_RESET = 32'd65536;
    localparam logic [CW-1:0]         UV_MAX      = 32'h7FFF_FFFF;
    localparam logic [CW-1:0]         UV_MIN      = 32'h8000_0000;
    localparam logic signed [SHW-1:0] K_BITS      = 8'sd31;

    typedef logic [CW-1:0]             word_t;
    typedef logic [NVERT-1:0][CW-1:0]  vert_t;

    typedef struct packed {
        vert_t vert;
        logic  last;
    } face_t;

    typedef struct packed {
        logic [2:0][MW-1:0]     mag;
        logic [2:0]             neg;
        logic signed [SHW-1:0]  shift;
        logic [1:0]             drop;
        logic                   degen;
        vert_t                  vert;
        logic                   last;
    } cls_t;

    typedef struct packed {
        logic [5:0][CW-1:0] uv;
        logic [1:0]         drop;
        logic               degen;
        logic               last;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [2:0][KW-1:0] k;
        logic [2:0]         neg;
    } sqt_t;

    function automatic logic signed [PW-1:0] mul_e(input logic signed [EW-1:0] a,
                                                   input logic signed [EW-1:0] b);
        return PW'(a) * PW'(b);
    endfunction

    function automatic logic signed [UVW-1:0] uv_mul(input word_t c, input word_t s);
        logic signed [UVW-1:0] a;
        logic signed [UVW-1:0] b;
        a = UVW'(signed'(c));
        b = signed'(UVW'(s));
        return a * b;
    endfunction

    function automatic word_t uv_sat(input logic signed [UVW-1:0] p);
        logic [QUVW-1:0] q;
        q = p[UVW-1:UV_SHIFT];
        if ((&q[QUVW-1:CW-1]) || !(|q[QUVW-1:CW-1])) begin
            return q[CW-1:0];
        end
        return q[QUVW-1] ? UV_MIN : UV_MAX;
    endfunction

    function automatic logic [SQW-1:0] sq_k(input logic [KW-1:0] k);
        return SQW'(k) * SQW'(k);
    endfunction

endpackage

// File: hw/rtl/triangle_normal_and_planar_uv.sv
// Pipeline: the accepting stage and 6 classify stages after it, a result queue,
// then 54 stages of scaling, square root and divide.
// Throughput: one triangle per cycle unless m_ready holds the output back; the
// 32-step square root and 17-step divider are fully pipelined, one bit per stage.
// Reset: synchronous, active low; clears all valid state and sets scale_reg to 1.0.
// No memory clearing pass.
module triangle_normal_and_planar_uv (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tnpu_pkg::CW-1:0]        cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [tnpu_pkg::CW-1:0] s_a_x,
    input  logic signed [tnpu_pkg::CW-1:0] s_a_y,
    input  logic signed [tnpu_pkg::CW-1:0] s_a_z,
    input  logic signed [tnpu_pkg::CW-1:0] s_b_x,
    input  logic signed [tnpu_pkg::CW-1:0] s_b_y,
    input  logic signed [tnpu_pkg::CW-1:0] s_b_z,
    input  logic signed [tnpu_pkg::CW-1:0] s_c_x,
    input  logic signed [tnpu_pkg::CW-1:0] s_c_y,
    input  logic signed [tnpu_pkg::CW-1:0] s_c_z,
    input  logic                           s_last_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [tnpu_pkg::CW-1:0] m_a_u,
    output logic signed [tnpu_pkg::CW-1:0] m_a_v,
    output logic signed [tnpu_pkg::CW-1:0] m_b_u,
    output logic signed [tnpu_pkg::CW-1:0] m_b_v,
    output logic signed [tnpu_pkg::CW-1:0] m_c_u,
    output logic signed [tnpu_pkg::CW-1:0] m_c_v,
    output logic [tnpu_pkg::QW-1:0]        m_norm_x,
    output logic [tnpu_pkg::QW-1:0]        m_norm_y,
    output logic [tnpu_pkg::QW-1:0]        m_norm_z,
    output logic [1:0]                     m_drop_axis,
    output logic                           m_degenerate,
    output logic                           m_last_out
);
    import tnpu_pkg::*;

    word_t              scale_reg;
    face_t              in_face;
    logic               cls_valid;
    logic               cls_ready;
    cls_t               cls_item;
    logic               q_valid;
    logic               q_ready;
    cls_t               q_item;
    side_t              side;
    logic [2:0][QW-1:0] norm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (cfg_wr_en) begin
            scale_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        in_face.vert[0] = s_a_x;
        in_face.vert[1] = s_a_y;
        in_face.vert[2] = s_a_z;
        in_face.vert[3] = s_b_x;
        in_face.vert[4] = s_b_y;
        in_face.vert[5] = s_b_z;
        in_face.vert[6] = s_c_x;
        in_face.vert[7] = s_c_y;
        in_face.vert[8] = s_c_z;
        in_face.last    = s_last_in;
    end

    tnpu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_face    (in_face),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_item  (cls_item)
    );

    tnpu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_item   (cls_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    tnpu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .scale    (scale_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_side   (side),
        .m_norm   (norm)
    );

    assign m_a_u        = side.uv[0];
    assign m_a_v        = side.uv[1];
    assign m_b_u        = side.uv[2];
    assign m_b_v        = side.uv[3];
    assign m_c_u        = side.uv[4];
    assign m_c_v        = side.uv[5];
    assign m_norm_x     = norm[0];
    assign m_norm_y     = norm[1];
    assign m_norm_z     = norm[2];
    assign m_drop_axis  = side.drop;
    assign m_degenerate = side.degen;
    assign m_last_out   = side.last;

endmodule

// File: hw/rtl/tnpu_front.sv
module tnpu_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tnpu_pkg::face_t s_face,
    output logic            out_valid,
    input  logic            out_ready,
    output tnpu_pkg::cls_t  out_item
);
    import tnpu_pkg::*;

    localparam int NST = 7;

    logic [NST-1:0]           vld_reg;
    logic                     adv;
    face_t                    face_reg [NST-1];
    logic signed [EW-1:0]     e1_reg [3];
    logic signed [EW-1:0]     e2_reg [3];
    logic signed [PW-1:0]     prod_reg [6];
    logic signed [NW-1:0]     n_reg [3];
    logic [2:0][MW-1:0]       mag4_reg;
    logic [2:0]               neg4_reg;
    logic [2:0][MW-1:0]       mag5_reg;
    logic [2:0]               neg5_reg;
    logic [1:0]               drop5_reg;
    logic                     degen5_reg;
    logic [NCHUNK-1:0]        cnz_reg;
    logic [NCHUNK-1:0][CLW-1:0] cloc_reg;
    cls_t                     out_reg;

    logic [CHW-1:0]           orw;
    logic [1:0]               drop_c;
    logic                     degen_c;
    logic [NCHUNK-1:0]        cnz_c;
    logic [NCHUNK-1:0][CLW-1:0] cloc_c;
    logic [CIW-1:0]           top;
    logic [BLW-1:0]           blen;
    logic signed [SHW-1:0]    sh_c;

    // hold the whole line only when the last stage is full and the queue is full
    assign adv       = !vld_reg[NST-1] || out_ready;
    assign s_ready   = adv;
    assign out_valid = vld_reg[NST-1];
    assign out_item  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // bit length of the largest magnitude equals that of the OR of all three
    always_comb begin
        orw     = CHW'(mag4_reg[0] | mag4_reg[1] | mag4_reg[2]);
        degen_c = ~|orw;
        if (mag4_reg[0] > mag4_reg[1] && mag4_reg[0] > mag4_reg[2]) begin
            drop_c = DROP_X;
        end else if (mag4_reg[1] > mag4_reg[0] && mag4_reg[1] > mag4_reg[2]) begin
            drop_c = DROP_Y;
        end else begin
            drop_c = DROP_Z;
        end
        for (int c = 0; c < NCHUNK; c++) begin
            cnz_c[c]  = |orw[c*CHUNK +: CHUNK];
            cloc_c[c] = '0;
            for (int b = 0; b < CHUNK; b++) begin
                if (orw[c*CHUNK + b]) begin
                    cloc_c[c] = CLW'(b + 1);
                end
            end
        end
    end

    always_comb begin
        top = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            if (cnz_reg[c]) begin
                top = CIW'(c);
            end
        end
        blen = BLW'(top) * BLW'(CHUNK) + BLW'(cloc_reg[top]);
        sh_c = signed'({1'b0, blen}) - K_BITS;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            face_reg[0] <= s_face;
            for (int s = 1; s < NST-1; s++) begin
                face_reg[s] <= face_reg[s-1];
            end
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= EW'(signed'(face_reg[0].vert[3+i])) - EW'(signed'(face_reg[0].vert[i]));
                e2_reg[i] <= EW'(signed'(face_reg[0].vert[6+i])) - EW'(signed'(face_reg[0].vert[i]));
            end
            prod_reg[0] <= mul_e(e1_reg[1], e2_reg[2]);
            prod_reg[1] <= mul_e(e1_reg[2], e2_reg[1]);
            prod_reg[2] <= mul_e(e1_reg[2], e2_reg[0]);
            prod_reg[3] <= mul_e(e1_reg[0], e2_reg[2]);
            prod_reg[4] <= mul_e(e1_reg[0], e2_reg[1]);
            prod_reg[5] <= mul_e(e1_reg[1], e2_reg[0]);
            for (int i = 0; i < 3; i++) begin
                n_reg[i]    <= NW'(prod_reg[2*i]) - NW'(prod_reg[2*i+1]);
                neg4_reg[i] <= n_reg[i][NW-1];
                mag4_reg[i] <= n_reg[i][NW-1] ? MW'(-n_reg[i]) : MW'(n_reg[i]);
            end
            mag5_reg   <= mag4_reg;
            neg5_reg   <= neg4_reg;
            drop5_reg  <= drop_c;
            degen5_reg <= degen_c;
            cnz_reg    <= cnz_c;
            cloc_reg   <= cloc_c;
            out_reg.mag   <= mag5_reg;
            out_reg.neg   <= neg5_reg;
            out_reg.shift <= sh_c;
            out_reg.drop  <= drop5_reg;
            out_reg.degen <= degen5_reg;
            out_reg.vert  <= face_reg[NST-2].vert;
            out_reg.last  <= face_reg[NST-2].last;
        end
    end

endmodule

// File: hw/rtl/tnpu_queue.sv
module tnpu_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tnpu_pkg::cls_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output tnpu_pkg::cls_t out_item
);
    import tnpu_pkg::*;

    cls_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_reg;
    logic [QAW-1:0] rd_reg;
    logic [QCW-1:0] cnt_reg;
    logic           push;
    logic           pop;

    assign in_ready  = cnt_reg != QCW'(QDEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

endmodule

// File: hw/rtl/tnpu_sqrt.sv
module tnpu_sqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [tnpu_pkg::SW-1:0]      s_in,
    input  tnpu_pkg::sqt_t               tag_in,
    output logic [tnpu_pkg::LW-1:0]      root_out,
    output tnpu_pkg::sqt_t               tag_out
);
    import tnpu_pkg::*;

    logic [RW-1:0] rem_reg  [SQRT_STEPS];
    logic [LW-1:0] root_reg [SQRT_STEPS];
    logic [SW-1:0] s_reg    [SQRT_STEPS];
    sqt_t          tag_reg  [SQRT_STEPS];

    // one result bit per stage, most significant first
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        logic [RW-1:0]   rem_src;
        logic [LW-1:0]   root_src;
        logic [SW-1:0]   s_src;
        sqt_t            tag_src;
        logic [RW+1:0]   cur;
        logic [RW+1:0]   trial;
        logic            ge;

        if (j == 0) begin : g_head
            assign rem_src  = '0;
            assign root_src = '0;
            assign s_src    = s_in;
            assign tag_src  = tag_in;
        end else begin : g_body
            assign rem_src  = rem_reg[j-1];
            assign root_src = root_reg[j-1];
            assign s_src    = s_reg[j-1];
            assign tag_src  = tag_reg[j-1];
        end

        assign cur   = {rem_src, s_src[SW-1:SW-2]};
        assign trial = (RW+2)'({root_src, 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= ge ? RW'(cur - trial) : RW'(cur);
                root_reg[j] <= {root_src[LW-2:0], ge};
                s_reg[j]    <= {s_src[SW-3:0], 2'b00};
                tag_reg[j]  <= tag_src;
            end
        end
    end

    assign root_out = root_reg[SQRT_STEPS-1];
    assign tag_out  = tag_reg[SQRT_STEPS-1];

endmodule

// File: hw/rtl/tnpu_div.sv
module tnpu_div (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [2:0][tnpu_pkg::DW-1:0]    d_in,
    input  logic [tnpu_pkg::LW-1:0]         l_in,
    input  tnpu_pkg::side_t                 side_in,
    output logic [2:0][tnpu_pkg::QW-1:0]    q_out,
    output tnpu_pkg::side_t                 side_out
);
    import tnpu_pkg::*;

    logic [2:0][LW-1:0] rem_reg  [DIV_STEPS];
    logic [2:0][QW-1:0] dl_reg   [DIV_STEPS];
    logic [2:0][QW-1:0] q_reg    [DIV_STEPS];
    logic [LW-1:0]      l_reg    [DIV_STEPS];
    side_t              side_reg [DIV_STEPS];

    // restoring division, one quotient bit per stage for each of the three lanes
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [2:0][LW-1:0] rem_src;
        logic [2:0][QW-1:0] dl_src;
        logic [2:0][QW-1:0] q_src;
        logic [LW-1:0]      l_src;
        side_t              side_src;
        logic [2:0][LW:0]   cur;
        logic [2:0]         ge;

        if (j == 0) begin : g_head
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    rem_src[i] = d_in[i][DW-1:QW];
                    dl_src[i]  = d_in[i][QW-1:0];
                end
                q_src    = '0;
                l_src    = l_in;
                side_src = side_in;
            end
        end else begin : g_body
            assign rem_src  = rem_reg[j-1];
            assign dl_src   = dl_reg[j-1];
            assign q_src    = q_reg[j-1];
            assign l_src    = l_reg[j-1];
            assign side_src = side_reg[j-1];
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                cur[i] = {rem_src[i], dl_src[i][QW-1]};
                ge[i]  = cur[i] >= {1'b0, l_src};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[j][i] <= ge[i] ? LW'(cur[i] - {1'b0, l_src}) : LW'(cur[i]);
                    dl_reg[j][i]  <= {dl_src[i][QW-2:0], 1'b0};
                    q_reg[j][i]   <= {q_src[i][QW-2:0], ge[i]};
                end
                l_reg[j]    <= l_src;
                side_reg[j] <= side_src;
            end
        end
    end

    assign q_out    = q_reg[DIV_STEPS-1];
    assign side_out = side_reg[DIV_STEPS-1];

endmodule

// File: hw/rtl/tnpu_back.sv
module tnpu_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tnpu_pkg::cls_t               in_item,
    input  tnpu_pkg::word_t              scale,
    output logic                         m_valid,
    input  logic                         m_ready,
    output tnpu_pkg::side_t              m_side,
    output logic [2:0][tnpu_pkg::QW-1:0] m_norm
);
    import tnpu_pkg::*;

    localparam int NST = 3 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    logic [NST-1:0]        vld_reg;
    logic                  adv;

    logic [1:0]            u0;
    logic [1:0]            u1;
    word_t                 cu [6];
    logic signed [SHW-1:0] nsh;
    logic [2:0][KW-1:0]    kx;

    logic [2:0][KW-1:0]    k0_reg;
    logic [2:0]            neg0_reg;
    logic signed [UVW-1:0] p0_reg [6];
    logic [1:0]            drop0_reg;
    logic                  degen0_reg;
    logic                  last0_reg;

    logic [SQW-1:0]        sq1_reg [3];
    logic [2:0][KW-1:0]    k1_reg;
    logic [2:0]            neg1_reg;
    side_t                 side1_reg;

    logic [SW-1:0]         s2_reg;
    sqt_t                  tag2_reg;

    logic [LW-1:0]         root;
    sqt_t                  tag_sq;

    logic [2:0][DW-1:0]    d3_reg;
    logic [LW-1:0]         l3_reg;
    side_t                 side3_reg;

    logic [2:0][QW-1:0]    q_div;
    side_t                 side_div;

    logic [2:0][QW-1:0]    norm_reg;
    side_t                 side_out_reg;

    assign adv      = !vld_reg[NST-1] || m_ready;
    assign in_ready = adv;
    assign m_valid  = vld_reg[NST-1];
    assign m_side   = side_out_reg;
    assign m_norm   = norm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // pick the kept coordinates and bring the largest magnitude to 31 bits
    always_comb begin
        u0  = (in_item.drop == DROP_X) ? 2'd1 : 2'd0;
        u1  = (in_item.drop == DROP_Z) ? 2'd1 : 2'd2;
        nsh = -in_item.shift;
        for (int v = 0; v < 3; v++) begin
            cu[2*v]   = in_item.vert[3*v + u0];
            cu[2*v+1] = in_item.vert[3*v + u1];
        end
        for (int i = 0; i < 3; i++) begin
            if (in_item.shift > 8'sd0) begin
                kx[i] = KW'(in_item.mag[i] >> in_item.shift[5:0]);
            end else begin
                kx[i] = KW'(in_item.mag[i] << nsh[5:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            k0_reg     <= kx;
            neg0_reg   <= in_item.neg;
            drop0_reg  <= in_item.drop;
            degen0_reg <= in_item.degen;
            last0_reg  <= in_item.last;
            for (int u = 0; u < 6; u++) begin
                p0_reg[u] <= uv_mul(cu[u], scale);
            end

            for (int i = 0; i < 3; i++) begin
                sq1_reg[i] <= sq_k(k0_reg[i]);
            end
            k1_reg   <= k0_reg;
            neg1_reg <= neg0_reg;
            for (int u = 0; u < 6; u++) begin
                side1_reg.uv[u] <= uv_sat(p0_reg[u]);
            end
            side1_reg.drop  <= drop0_reg;
            side1_reg.degen <= degen0_reg;
            side1_reg.last  <= last0_reg;

            s2_reg        <= SW'(sq1_reg[0]) + SW'(sq1_reg[1]) + SW'(sq1_reg[2]);
            tag2_reg.side <= side1_reg;
            tag2_reg.k    <= k1_reg;
            tag2_reg.neg  <= neg1_reg;

            // numerator scaled by 2^15 with half the length added for rounding
            for (int i = 0; i < 3; i++) begin
                d3_reg[i] <= DW'({tag_sq.neg[i] ? NUMW'(root) - NUMW'(tag_sq.k[i])
                                                : NUMW'(root) + NUMW'(tag_sq.k[i]),
                                  {FRAC{1'b0}}}) + DW'(root >> 1);
            end
            l3_reg    <= root;
            side3_reg <= tag_sq.side;

            for (int i = 0; i < 3; i++) begin
                norm_reg[i] <= side_div.degen ? NORM_HALF : q_div[i];
            end
            side_out_reg <= side_div;
        end
    end

    tnpu_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (adv),
        .s_in     (s2_reg),
        .tag_in   (tag2_reg),
        .root_out (root),
        .tag_out  (tag_sq)
    );

    tnpu_div u_div (
        .aclk     (aclk),
        .en       (adv),
        .d_in     (d3_reg),
        .l_in     (l3_reg),
        .side_in  (side3_reg),
        .q_out    (q_div),
        .side_out (side_div)
    );

endmodule

// File: hw/rtl/tnpu_checker.sv
`include "assert_macros.svh"

module tnpu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [tnpu_pkg::QW-1:0]        m_norm_x,
    input logic [tnpu_pkg::QW-1:0]        m_norm_y,
    input logic [tnpu_pkg::QW-1:0]        m_norm_z,
    input logic [1:0]                     m_drop_axis,
    input logic                           m_degenerate
);
    import tnpu_pkg::*;

    // a stalled result stays on offer
    `ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid, "result dropped while stalled")

    // a flat triangle gives the half normal and the xy projection
    `ASSERT_IMPL(a_degen_out, m_valid && m_degenerate, m_norm_x == NORM_HALF && m_norm_y == NORM_HALF && m_norm_z == NORM_HALF && m_drop_axis == DROP_Z, "bad degenerate result")

    // biased normal never exceeds one
    `ASSERT_IMPL(a_norm_range, m_valid, m_norm_x <= NORM_ONE && m_norm_y <= NORM_ONE && m_norm_z <= NORM_ONE, "normal out of range")

    // nothing is offered straight after reset
    `ASSERT_RST(a_reset_idle, !aresetn, !m_valid, "result valid after reset")

endmodule

bind triangle_normal_and_planar_uv tnpu_checker u_tnpu_checker (.*);

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tnpu_pkg::*;

    typedef struct packed {
        word_t ax, ay, az, bx, by, bz, cx, cy, cz;
        logic  last;
    } face_s;

    typedef struct packed {
        word_t          au, av, bu, bv, cu, cv;
        logic [QW-1:0]  nx, ny, nz;
        logic [1:0]     drop;
        logic           degen;
        logic           last;
    } uvnorm_s;

    typedef struct packed {
        face_s   f;
        logic    known;
        uvnorm_s r;
    } dir_row_s;

    localparam int    PHASE_ITEMS = 270;
    localparam int    DRAIN_WAIT  = 80;
    localparam int    DIR_ROWS    = 13;
    localparam word_t ONE         = 32'd65536;
    localparam word_t NEG_ONE     = 32'hFFFF_0000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    word_t cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_a_x = '0, s_a_y = '0, s_a_z = '0;
    logic signed [CW-1:0] s_b_x = '0, s_b_y = '0, s_b_z = '0;
    logic signed [CW-1:0] s_c_x = '0, s_c_y = '0, s_c_z = '0;
    logic s_last_in = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [CW-1:0] m_a_u, m_a_v, m_b_u, m_b_v, m_c_u, m_c_v;
    logic [QW-1:0] m_norm_x, m_norm_y, m_norm_z;
    logic [1:0] m_drop_axis;
    logic m_degenerate, m_last_out;

    uvnorm_s pending_faces[$];
    word_t   uv_scale = SCALE_RESET;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      failed = 1'b0;

    triangle_normal_and_planar_uv u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_x(s_a_x), .s_a_y(s_a_y), .s_a_z(s_a_z),
        .s_b_x(s_b_x), .s_b_y(s_b_y), .s_b_z(s_b_z),
        .s_c_x(s_c_x), .s_c_y(s_c_y), .s_c_z(s_c_z),
        .s_last_in(s_last_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_a_u(m_a_u), .m_a_v(m_a_v), .m_b_u(m_b_u), .m_b_v(m_b_v),
        .m_c_u(m_c_u), .m_c_v(m_c_v),
        .m_norm_x(m_norm_x), .m_norm_y(m_norm_y), .m_norm_z(m_norm_z),
        .m_drop_axis(m_drop_axis), .m_degenerate(m_degenerate), .m_last_out(m_last_out)
    );

    always #10 aclk = ~aclk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic word_t scaled_uv(input word_t c);
        logic signed [63:0] p;
        logic signed [63:0] q;
        p = $signed({{32{c[31]}}, c}) * $signed({32'b0, uv_scale});
        q = p >>> 16;
        if (q > 64'sd2147483647) return UV_MAX;
        if (q < -64'sd2147483648) return UV_MIN;
        return q[31:0];
    endfunction

    function automatic uvnorm_s face_uvnorm(input face_s f);
        word_t              vv[9];
        logic signed [32:0] e1[3], e2[3];
        logic signed [69:0] n[3];
        logic [69:0]        m[3];
        logic [69:0]        big;
        logic [63:0]        k[3];
        logic [63:0]        s, len, num;
        logic [QW-1:0]      nrm[3];
        int                 bl, sh, u0, u1;
        uvnorm_s            r;
        vv = '{f.ax, f.ay, f.az, f.bx, f.by, f.bz, f.cx, f.cy, f.cz};
        for (int i = 0; i < 3; i++) begin
            e1[i] = $signed({vv[3+i][31], vv[3+i]}) - $signed({vv[i][31], vv[i]});
            e2[i] = $signed({vv[6+i][31], vv[6+i]}) - $signed({vv[i][31], vv[i]});
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int i = 0; i < 3; i++) m[i] = n[i][69] ? -n[i] : n[i];
        r.degen = (m[0] == 0) && (m[1] == 0) && (m[2] == 0);
        if (m[0] > m[1] && m[0] > m[2]) r.drop = DROP_X;
        else if (m[1] > m[0] && m[1] > m[2]) r.drop = DROP_Y;
        else r.drop = DROP_Z;
        if (r.degen) begin
            nrm = '{NORM_HALF, NORM_HALF, NORM_HALF};
        end else begin
            big = m[0];
            if (m[1] > big) big = m[1];
            if (m[2] > big) big = m[2];
            bl = 0;
            for (int j = 0; j < 70; j++) if (big[j]) bl = j + 1;
            sh = bl - 31;
            s = '0;
            for (int i = 0; i < 3; i++) begin
                k[i] = (sh >= 0) ? 64'(m[i] >> sh) : 64'(m[i] << (-sh));
                s = s + k[i] * k[i];
            end
            len = int_sqrt(s);
            for (int i = 0; i < 3; i++) begin
                num = n[i][69] ? len - k[i] : len + k[i];
                nrm[i] = QW'(((num << 15) + (len >> 1)) / len);
            end
        end
        r.nx = nrm[0];
        r.ny = nrm[1];
        r.nz = nrm[2];
        u0 = (r.drop == DROP_X) ? 1 : 0;
        u1 = (r.drop == DROP_Z) ? 1 : 2;
        r.au = scaled_uv(vv[u0]);
        r.av = scaled_uv(vv[u1]);
        r.bu = scaled_uv(vv[3+u0]);
        r.bv = scaled_uv(vv[3+u1]);
        r.cu = scaled_uv(vv[6+u0]);
        r.cv = scaled_uv(vv[6+u1]);
        r.last = f.last;
        return r;
    endfunction

    function automatic word_t pick_coord(input int kind);
        word_t extremes[6];
        extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF, ONE};
        case (kind)
            0: return $urandom;
            1: return word_t'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default: return extremes[$urandom_range(0, 5)];
        endcase
    endfunction

    function automatic face_s random_face();
        face_s f;
        int    kind, sel;
        word_t d;
        kind = $urandom_range(0, 9);
        sel = (kind <= 2) ? 0 : (kind == 9) ? 2 : 1;
        f = '{pick_coord(sel), pick_coord(sel), pick_coord(sel),
              pick_coord(sel), pick_coord(sel), pick_coord(sel),
              pick_coord(sel), pick_coord(sel), pick_coord(sel),
              1'($urandom_range(0, 1))};
        case (kind)
            7: begin
                // collinear vertices: c = a + 2*(b - a)
                f.cx = f.ax + 2 * (f.bx - f.ax);
                f.cy = f.ay + 2 * (f.by - f.ay);
                f.cz = f.az + 2 * (f.bz - f.az);
            end
            8: begin
                // flat in one plane, sometimes on a 45 degree slope for ties
                d = $urandom_range(0, 1) ? 32'd0 : pick_coord(1);
                case ($urandom_range(0, 2))
                    0: begin f.bx = f.ax; f.cx = f.ax; end
                    1: begin f.by = f.ay; f.cy = f.ay; end
                    default: begin
                        f.bz = f.az;
                        f.cz = f.az;
                        if (d != 0) begin
                            f.bx = f.ax + d; f.by = f.ay + d;
                        end
                    end
                endcase
            end
            default: ;
        endcase
        return f;
    endfunction

    task automatic send_face(input face_s f, input logic known, input uvnorm_s typed);
        uvnorm_s exp_r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_a_x <= f.ax; s_a_y <= f.ay; s_a_z <= f.az;
        s_b_x <= f.bx; s_b_y <= f.by; s_b_z <= f.bz;
        s_c_x <= f.cx; s_c_y <= f.cy; s_c_z <= f.cz;
        s_last_in <= f.last;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp_r = known ? typed : face_uvnorm(f);
        pending_faces = {pending_faces, exp_r};
    endtask

    task automatic drain();
        while (pending_faces.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string nm, input word_t exp_v, input word_t got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", nm, exp_v, got_v);
            failed = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        uvnorm_s e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_faces.size() == 0) begin
                $error("result item with nothing expected");
                failed = 1'b1;
            end else begin
                e = pending_faces.pop_front();
                check_field("a_u", e.au, m_a_u);
                check_field("a_v", e.av, m_a_v);
                check_field("b_u", e.bu, m_b_u);
                check_field("b_v", e.bv, m_b_v);
                check_field("c_u", e.cu, m_c_u);
                check_field("c_v", e.cv, m_c_v);
                check_field("norm_x", e.nx, m_norm_x);
                check_field("norm_y", e.ny, m_norm_y);
                check_field("norm_z", e.nz, m_norm_z);
                check_field("drop_axis", e.drop, m_drop_axis);
                check_field("degenerate", e.degen, m_degenerate);
                check_field("last_out", e.last, m_last_out);
            end
        end
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial begin
        #20ms;
        $display("[triangle_normal_and_planar_uv] ERROR");
        $finish;
    end

    initial begin
        dir_row_s dir_tab[DIR_ROWS];
        word_t    scales[6];
        scales = '{SCALE_RESET, 32'hFFFF_FFFF, 32'd0, 32'd1, $urandom, 32'd65536 * 300};

        dir_tab[0] = '{f: '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0}, known: 1'b1,
            r: '{0, 0, 0, 0, 0, 0, NORM_HALF, NORM_HALF, NORM_HALF, DROP_Z, 1'b1, 1'b0}};
        dir_tab[1] = '{f: '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1'b1}, known: 1'b1,
            r: '{0, 0, ONE, 0, 0, ONE, NORM_HALF, NORM_HALF, NORM_ONE, DROP_Z, 1'b0, 1'b1}};
        dir_tab[2] = '{f: '{0, 0, 0, 0, ONE, 0, ONE, 0, 0, 1'b0}, known: 1'b1,
            r: '{0, 0, 0, ONE, ONE, 0, NORM_HALF, NORM_HALF, 17'd0, DROP_Z, 1'b0, 1'b0}};
        dir_tab[3] = '{f: '{0, 0, 0, 0, ONE, 0, 0, 0, ONE, 1'b0}, known: 1'b0, r: '0};
        dir_tab[4] = '{f: '{0, 0, 0, ONE, 0, 0, 0, 0, ONE, 1'b0}, known: 1'b0, r: '0};
        dir_tab[5] = '{f: '{0, 0, 0, ONE, NEG_ONE, 0, 0, ONE, ONE, 1'b1}, known: 1'b0,
            r: '0};
        dir_tab[6] = '{f: '{0, 0, 0, ONE, ONE, 0, 0, 0, ONE, 1'b0}, known: 1'b0, r: '0};
        dir_tab[7] = '{f: '{ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0, 1'b0}, known: 1'b0,
            r: '0};
        dir_tab[8] = '{f: '{UV_MIN, UV_MIN, UV_MIN, UV_MAX, UV_MIN, UV_MIN,
            UV_MIN, UV_MAX, UV_MIN, 1'b0}, known: 1'b0, r: '0};
        dir_tab[9] = '{f: '{UV_MAX, UV_MIN, UV_MAX, UV_MIN, UV_MAX, UV_MIN,
            UV_MAX, UV_MAX, UV_MIN, 1'b1}, known: 1'b0, r: '0};
        dir_tab[10] = '{f: '{UV_MAX, UV_MAX, UV_MAX, UV_MIN, UV_MIN, UV_MIN,
            UV_MAX, UV_MIN, UV_MAX, 1'b0}, known: 1'b0, r: '0};
        dir_tab[11] = '{f: '{32'hFFFF_FFFF, 0, 1, 1, 32'hFFFF_FFFF, 0, 0, 1,
            32'hFFFF_FFFF, 1'b0}, known: 1'b0, r: '0};
        dir_tab[12] = '{f: '{5, 7, 9, 5, 7, 9, 1, 2, 3, 1'b0}, known: 1'b0, r: '0};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 30;
        recv_idle_pct = 50;
        foreach (dir_tab[i]) send_face(dir_tab[i].f, dir_tab[i].known, dir_tab[i].r);

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 50 : 0;
            recv_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 30 : 0;
            if (ph > 0) begin
                // hold the stream and let the pipe empty before touching the scale
                s_valid <= 1'b0;
                drain();
                repeat (DRAIN_WAIT) @(posedge aclk);
                cfg_wr_en <= 1'b1;
                cfg_wr_data <= scales[ph];
                @(posedge aclk);
                cfg_wr_en <= 1'b0;
                uv_scale = scales[ph];
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 100) begin
                    s_valid <= 1'b0;
                    drain();
                end
                send_face(random_face(), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (!failed) begin
            $display("[triangle_normal_and_planar_uv] OK");
        end else begin
            $display("[triangle_normal_and_planar_uv] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tnpu_pkg.sv
hw/rtl/tnpu_front.sv
hw/rtl/tnpu_queue.sv
hw/rtl/tnpu_sqrt.sv
hw/rtl/tnpu_div.sv
hw/rtl/tnpu_back.sv
hw/rtl/triangle_normal_and_planar_uv.sv
hw/rtl/tnpu_checker.sv
bench/tb_top.sv
